[rtl/gossip_membership_table_assert.svh]
// Assertion macros used by the membership table controller.
// They expect clk_i and rst_ni in the scope where they are used.
`ifndef GOSSIP_MEMBERSHIP_TABLE_ASSERT_SVH
`define GOSSIP_MEMBERSHIP_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GMT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/gmt_pkg.sv]
`default_nettype none

package gmt_pkg;

  localparam int NODE_SLOTS = 16;
  localparam int SLOT_W     = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;

  localparam int ID_W      = 8;
  localparam int BEAT_W    = 32;
  localparam int TIME_W    = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int MODE_W    = 2;
  localparam int OUTC_W    = 3;

  localparam logic [BEAT_W-1:0] FAREWELL_BEAT    = '1;
  localparam logic [ID_W-1:0]   SELF_ID_RST      = '0;
  localparam logic [CFG_W-1:0]  FAIL_TIMEOUT_RST = 16'd5000;
  localparam logic [CFG_W-1:0]  TOMB_HOLD_RST    = 16'd2000;

  localparam logic [ID_W:0]     SLOTS_EXT = (ID_W + 1)'(NODE_SLOTS);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NODE_SLOTS - 1);

  localparam logic [MODE_W-1:0] MODE_MERGE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ROUND = 2'd1;

  localparam logic [CFG_IDX_W-1:0] REG_SELF_ID      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAIL_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOMB_HOLD    = 2'd2;

  typedef enum logic [OUTC_W-1:0] {
    OC_SELF     = 3'd0,
    OC_TOMB     = 3'd1,
    OC_INSERT   = 3'd2,
    OC_RAISE    = 3'd3,
    OC_STALE    = 3'd4,
    OC_FAREWELL = 3'd5,
    OC_UNKNOWN  = 3'd6,
    OC_RANGE    = 3'd7
  } outcome_e;

  typedef enum logic {
    KIND_MERGE = 1'b0,
    KIND_LIST  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ASEL_ID   = 2'd0,
    ASEL_SELF = 2'd1,
    ASEL_SLOT = 2'd2
  } asel_e;

  typedef struct packed {
    logic [BEAT_W-1:0] hb;
    logic [TIME_W-1:0] ls;
    logic [TIME_W-1:0] tt;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic  capture;
    logic  rd_en;
    asel_e asel;
    logic  merge_wr;
    logic  bump_wr;
    logic  evict_wr;
    logic  list_load;
    logic  slot_clr;
    logic  slot_inc;
  } ctrl_cmd_t;

  typedef struct packed {
    logic self_in_range;
    logic slot_listed;
    logic slot_evict_cand;
    logic slot_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/gmt_ram.sv]
`default_nettype none

module gmt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/gmt_dp.sv]
`default_nettype none

module gmt_dp
  import gmt_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic [ID_W-1:0]      member_id_i,
  input  wire logic [BEAT_W-1:0]    beat_i,
  input  wire logic [TIME_W-1:0]    now_ms_i,
  input  wire ctrl_cmd_t            cmd_i,
  output dp_status_t                status_o,
  input  wire logic                 out_ready_i,
  output logic                      out_valid_o,
  output logic                      kind_o,
  output logic      [ID_W-1:0]      out_id_o,
  output logic      [BEAT_W-1:0]    out_beat_o,
  output logic      [OUTC_W-1:0]    outcome_o,
  output logic                      last_o
);

  logic [ID_W-1:0]       self_id_q;
  logic [CFG_W-1:0]      fail_timeout_q;
  logic [CFG_W-1:0]      tomb_hold_q;
  logic [ID_W-1:0]       id_q;
  logic [BEAT_W-1:0]     beat_q;
  logic [TIME_W-1:0]     now_q;
  logic [SLOT_W-1:0]     slot_q, slot_d;
  logic [NODE_SLOTS-1:0] present_q, tomb_q, hb_vld_q;

  logic                  out_vld_q, out_vld_d;
  kind_e                 kind_q;
  logic [ID_W-1:0]       oid_q;
  logic [BEAT_W-1:0]     obeat_q;
  outcome_e              outc_q;
  logic                  last_q;

  logic [SLOT_W-1:0]     self_idx, id_idx, addr;
  logic                  self_in_range, id_in_range;
  logic [NODE_SLOTS-1:0] listed, after;
  logic [ENTRY_W-1:0]    ram_rdata;
  entry_t                rd_ent, wr_ent;
  logic                  ram_we;
  logic [BEAT_W-1:0]     hb_cur;
  logic                  pres_cur, tomb_cur;
  logic [TIME_W-1:0]     age_tomb, age_seen;

  entry_t                m_ent, b_ent, e_ent;
  logic                  m_wr, m_pres, m_tomb, m_hbv;
  outcome_e              m_outc;
  logic [BEAT_W-1:0]     m_beat;
  logic                  e_exp;
  logic                  out_free, out_load;

  assign self_idx      = self_id_q[SLOT_W-1:0];
  assign id_idx        = id_q[SLOT_W-1:0];
  assign self_in_range = {1'b0, self_id_q} < SLOTS_EXT;
  assign id_in_range   = {1'b0, id_q} < SLOTS_EXT;

  always_comb begin
    unique case (cmd_i.asel)
      ASEL_ID:   addr = id_idx;
      ASEL_SELF: addr = self_idx;
      default:   addr = slot_q;
    endcase
  end

  always_comb begin
    for (int i = 0; i < NODE_SLOTS; i++) begin
      listed[i] = present_q[i] | (self_in_range && (self_idx == SLOT_W'(i)));
      after[i]  = listed[i] && (SLOT_W'(i) > slot_q);
    end
  end

  assign rd_ent   = entry_t'(ram_rdata);
  assign hb_cur   = hb_vld_q[addr] ? rd_ent.hb : '0;
  assign pres_cur = present_q[addr];
  assign tomb_cur = tomb_q[addr];
  assign age_tomb = now_q - rd_ent.tt;
  assign age_seen = now_q - rd_ent.ls;

  always_comb begin
    m_wr   = 1'b0;
    m_pres = pres_cur;
    m_tomb = tomb_cur;
    m_hbv  = 1'b0;
    m_ent  = rd_ent;
    m_ent.hb = hb_cur;
    m_outc = OC_SELF;
    m_beat = '0;
    if (id_q == self_id_q) begin
      m_outc = OC_SELF;
      m_beat = id_in_range ? hb_cur : '0;
    end else if (!id_in_range) begin
      m_outc = OC_RANGE;
    end else begin
      if (beat_q == FAREWELL_BEAT) begin
        if (pres_cur) begin
          m_pres   = 1'b0;
          m_tomb   = 1'b1;
          m_ent.tt = now_q;
          m_wr     = 1'b1;
          m_outc   = OC_FAREWELL;
        end else begin
          m_outc = OC_UNKNOWN;
        end
      end else if (tomb_cur && (age_tomb < {{(TIME_W - CFG_W){1'b0}}, tomb_hold_q})) begin
        m_outc = OC_TOMB;
      end else begin
        m_tomb = 1'b0;
        if (!pres_cur) begin
          m_pres   = 1'b1;
          m_ent.hb = beat_q;
          m_ent.ls = now_q;
          m_wr     = 1'b1;
          m_hbv    = 1'b1;
          m_outc   = OC_INSERT;
        end else if (beat_q > hb_cur) begin
          m_ent.hb = beat_q;
          m_ent.ls = now_q;
          m_wr     = 1'b1;
          m_outc   = OC_RAISE;
        end else begin
          m_outc = OC_STALE;
        end
      end
      m_beat = m_pres ? m_ent.hb : '0;
    end
  end

  always_comb begin
    b_ent    = rd_ent;
    b_ent.hb = hb_cur + 1'b1;
    b_ent.ls = now_q;
    e_ent    = rd_ent;
    e_ent.tt = now_q;
    e_exp    = age_seen > {{(TIME_W - CFG_W){1'b0}}, fail_timeout_q};
  end

  always_comb begin
    ram_we = 1'b0;
    wr_ent = e_ent;
    priority if (cmd_i.merge_wr) begin
      ram_we = m_wr;
      wr_ent = m_ent;
    end else if (cmd_i.bump_wr) begin
      ram_we = 1'b1;
      wr_ent = b_ent;
    end else if (cmd_i.evict_wr) begin
      ram_we = e_exp;
      wr_ent = e_ent;
    end else begin
      ram_we = 1'b0;
      wr_ent = e_ent;
    end
  end

  gmt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NODE_SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(addr),
    .wdata_i(wr_ent),
    .re_i   (cmd_i.rd_en),
    .raddr_i(addr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_id_q      <= SELF_ID_RST;
      fail_timeout_q <= FAIL_TIMEOUT_RST;
      tomb_hold_q    <= TOMB_HOLD_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SELF_ID:      self_id_q      <= cfg_data_i[ID_W-1:0];
        REG_FAIL_TIMEOUT: fail_timeout_q <= cfg_data_i;
        REG_TOMB_HOLD:    tomb_hold_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      id_q   <= member_id_i;
      beat_q <= beat_i;
      now_q  <= now_ms_i;
    end
  end

  always_comb begin
    slot_d = slot_q;
    priority if (cmd_i.capture || cmd_i.slot_clr) begin
      slot_d = '0;
    end else if (cmd_i.slot_inc) begin
      slot_d = slot_q + 1'b1;
    end else begin
      slot_d = slot_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q    <= '0;
      present_q <= '0;
      tomb_q    <= '0;
      hb_vld_q  <= '0;
    end else begin
      slot_q <= slot_d;
      if (cmd_i.merge_wr) begin
        present_q[addr] <= m_pres;
        tomb_q[addr]    <= m_tomb;
        if (m_hbv) begin
          hb_vld_q[addr] <= 1'b1;
        end
      end
      if (cmd_i.bump_wr) begin
        present_q[addr] <= 1'b1;
        hb_vld_q[addr]  <= 1'b1;
      end
      if (cmd_i.evict_wr && e_exp) begin
        present_q[addr] <= 1'b0;
        tomb_q[addr]    <= 1'b1;
      end
    end
  end

  assign out_free = !out_vld_q || out_ready_i;
  assign out_load = cmd_i.merge_wr || cmd_i.list_load;

  always_comb begin
    out_vld_d = out_vld_q;
    priority if (out_load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.merge_wr) begin
      kind_q  <= KIND_MERGE;
      oid_q   <= id_q;
      obeat_q <= m_beat;
      outc_q  <= m_outc;
      last_q  <= 1'b1;
    end else if (cmd_i.list_load) begin
      kind_q  <= KIND_LIST;
      oid_q   <= ID_W'(slot_q);
      obeat_q <= hb_cur;
      outc_q  <= OC_SELF;
      last_q  <= ~|after;
    end
  end

  assign status_o.self_in_range   = self_in_range;
  assign status_o.slot_listed     = listed[slot_q];
  assign status_o.slot_evict_cand = present_q[slot_q] &&
                                    !(self_in_range && (slot_q == self_idx));
  assign status_o.slot_last       = slot_q == SLOT_LAST;
  assign status_o.out_free        = out_free;

  assign out_valid_o = out_vld_q;
  assign kind_o      = kind_q;
  assign out_id_o    = oid_q;
  assign out_beat_o  = obeat_q;
  assign outcome_o   = outc_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

[rtl/gmt_ctrl.sv]
`default_nettype none
`include "gossip_membership_table_assert.svh"

module gmt_ctrl
  import gmt_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [MODE_W-1:0] mode_i,
  input  wire dp_status_t        status_i,
  output ctrl_cmd_t              cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MRD  = 9'b000000010,
    S_MEX  = 9'b000000100,
    S_BRD  = 9'b000001000,
    S_BWR  = 9'b000010000,
    S_ECHK = 9'b000100000,
    S_EWR  = 9'b001000000,
    S_LCHK = 9'b010000000,
    S_LOUT = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.asel = ASEL_SLOT;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          priority if (mode_i == MODE_MERGE) begin
            state_d = S_MRD;
          end else if (mode_i == MODE_ROUND) begin
            state_d = status_i.self_in_range ? S_BRD : S_ECHK;
          end else begin
            state_d = S_LCHK;
          end
        end
      end
      S_MRD: begin
        cmd_o.asel  = ASEL_ID;
        cmd_o.rd_en = 1'b1;
        state_d     = S_MEX;
      end
      S_MEX: begin
        cmd_o.asel = ASEL_ID;
        if (status_i.out_free) begin
          cmd_o.merge_wr = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_BRD: begin
        cmd_o.asel  = ASEL_SELF;
        cmd_o.rd_en = 1'b1;
        state_d     = S_BWR;
      end
      S_BWR: begin
        cmd_o.asel    = ASEL_SELF;
        cmd_o.bump_wr = 1'b1;
        state_d       = S_ECHK;
      end
      S_ECHK: begin
        priority if (status_i.slot_evict_cand) begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_EWR;
        end else if (status_i.slot_last) begin
          cmd_o.slot_clr = 1'b1;
          state_d        = S_LCHK;
        end else begin
          cmd_o.slot_inc = 1'b1;
        end
      end
      S_EWR: begin
        cmd_o.evict_wr = 1'b1;
        if (status_i.slot_last) begin
          cmd_o.slot_clr = 1'b1;
          state_d        = S_LCHK;
        end else begin
          cmd_o.slot_inc = 1'b1;
          state_d        = S_ECHK;
        end
      end
      S_LCHK: begin
        priority if (status_i.slot_listed) begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_LOUT;
        end else if (status_i.slot_last) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.slot_inc = 1'b1;
        end
      end
      S_LOUT: begin
        if (status_i.out_free) begin
          cmd_o.list_load = 1'b1;
          if (status_i.slot_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.slot_inc = 1'b1;
            state_d        = S_LCHK;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `GMT_ASSERT_NEXT(a_read_consumed, cmd_o.rd_en, (state_q == S_MEX) || (state_q == S_BWR) || (state_q == S_EWR) || (state_q == S_LOUT), "Table read is not followed by a state that uses its data.")
  `GMT_ASSERT_NOW(a_load_when_free, cmd_o.merge_wr || cmd_o.list_load, status_i.out_free, "Result loaded while the output register still holds an untaken result.")
  `GMT_ASSERT_NEXT(a_busy_after_request, in_valid_i && in_ready_o, !in_ready_o, "A new request was taken before the previous one was processed.")

endmodule

`default_nettype wire

[rtl/gossip_membership_table.sv]
// Merge request: the entry is read in S_MRD, and the result is loaded in S_MEX once
// the output is free. List request: a sweep over all slots, each listed one read and
// loaded, held by any result stall. Round request: the own heartbeat is bumped if in
// range, each slot is checked for eviction, then the listing sweep runs.
// Reset clears the presence, tombstone and heartbeat-written flags at once and loads the
// register defaults; the table memory itself needs no clearing pass.
`default_nettype none

module gossip_membership_table
  import gmt_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [MODE_W-1:0]    mode_i,
  input  wire logic [ID_W-1:0]      member_id_i,
  input  wire logic [BEAT_W-1:0]    beat_i,
  input  wire logic [TIME_W-1:0]    now_ms_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic                      kind_o,
  output logic      [ID_W-1:0]      out_id_o,
  output logic      [BEAT_W-1:0]    out_beat_o,
  output logic      [OUTC_W-1:0]    outcome_o,
  output logic                      last_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  gmt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .mode_i    (mode_i),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  gmt_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .member_id_i(member_id_i),
    .beat_i     (beat_i),
    .now_ms_i   (now_ms_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .kind_o     (kind_o),
    .out_id_o   (out_id_o),
    .out_beat_o (out_beat_o),
    .outcome_o  (outcome_o),
    .last_o     (last_o)
  );

endmodule

`default_nettype wire

[dv/gossip_membership_table_checker.sv]
module gossip_membership_table_checker
  import gmt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [MODE_W-1:0]    mode_i,
  input  logic [ID_W-1:0]      member_id_i,
  input  logic [BEAT_W-1:0]    beat_i,
  input  logic [TIME_W-1:0]    now_ms_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic                 kind_i,
  input  logic [ID_W-1:0]      out_id_i,
  input  logic [BEAT_W-1:0]    out_beat_i,
  input  logic [OUTC_W-1:0]    outcome_i,
  input  logic                 last_i,
  output int                   reports_pending_o,
  output int                   mismatch_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_CAP = 100;

  typedef struct packed {
    kind_e             kind;
    logic [ID_W-1:0]   id;
    logic [BEAT_W-1:0] beat;
    outcome_e          outcome;
    logic              last;
  } member_report_t;

  member_report_t expected_reports[$];

  logic [ID_W-1:0]       self_cfg;
  logic [CFG_W-1:0]      timeout_cfg;
  logic [CFG_W-1:0]      hold_cfg;
  logic [NODE_SLOTS-1:0] member_present;
  logic [NODE_SLOTS-1:0] tomb_valid;
  logic [BEAT_W-1:0]     member_beat    [NODE_SLOTS];
  logic [TIME_W-1:0]     member_seen_ms [NODE_SLOTS];
  logic [TIME_W-1:0]     tomb_stamp_ms  [NODE_SLOTS];

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned wanted);
    if (mismatch_count_o < PRINT_CAP) begin
      $display("%0t: %s wrong: got 0x%0h, wanted 0x%0h", $realtime, what, got, wanted);
    end
    mismatch_count_o++;
  endtask

  function automatic logic slot_listed(input int slot);
    return member_present[slot] || (ID_W'(slot) == self_cfg);
  endfunction

  function automatic void fold_heartbeat_record(input logic [ID_W-1:0] id,
                                                input logic [BEAT_W-1:0] beat,
                                                input logic [TIME_W-1:0] now);
    member_report_t rep;
    logic [SLOT_W-1:0] s;
    logic [TIME_W-1:0] tomb_age;
    s = id[SLOT_W-1:0];
    tomb_age = now - tomb_stamp_ms[s];
    rep.kind = KIND_MERGE;
    rep.id = id;
    rep.beat = '0;
    rep.last = 1'b1;
    if (id == self_cfg) begin
      rep.outcome = OC_SELF;
      if (id < NODE_SLOTS) begin
        rep.beat = member_beat[s];
      end
    end else if (id >= NODE_SLOTS) begin
      rep.outcome = OC_RANGE;
    end else begin
      if (beat == FAREWELL_BEAT) begin
        if (member_present[s]) begin
          member_present[s] = 1'b0;
          tomb_valid[s] = 1'b1;
          tomb_stamp_ms[s] = now;
          rep.outcome = OC_FAREWELL;
        end else begin
          rep.outcome = OC_UNKNOWN;
        end
      end else if (tomb_valid[s] && tomb_age < TIME_W'(hold_cfg)) begin
        rep.outcome = OC_TOMB;
      end else begin
        tomb_valid[s] = 1'b0;
        if (!member_present[s]) begin
          member_present[s] = 1'b1;
          member_beat[s] = beat;
          member_seen_ms[s] = now;
          rep.outcome = OC_INSERT;
        end else if (beat > member_beat[s]) begin
          member_beat[s] = beat;
          member_seen_ms[s] = now;
          rep.outcome = OC_RAISE;
        end else begin
          rep.outcome = OC_STALE;
        end
      end
      if (member_present[s]) begin
        rep.beat = member_beat[s];
      end
    end
    expected_reports.insert(expected_reports.size(), rep);
  endfunction

  function automatic void age_out_members(input logic [TIME_W-1:0] now);
    logic [SLOT_W-1:0] own;
    logic [TIME_W-1:0] idle;
    if (self_cfg < NODE_SLOTS) begin
      own = self_cfg[SLOT_W-1:0];
      member_beat[own] = member_beat[own] + 1'b1;
      member_seen_ms[own] = now;
      member_present[own] = 1'b1;
    end
    for (int i = 0; i < NODE_SLOTS; i++) begin
      idle = now - member_seen_ms[i];
      if (ID_W'(i) != self_cfg && member_present[i] && idle > TIME_W'(timeout_cfg)) begin
        member_present[i] = 1'b0;
        tomb_valid[i] = 1'b1;
        tomb_stamp_ms[i] = now;
      end
    end
  endfunction

  function automatic void enumerate_members();
    member_report_t rep;
    int final_slot;
    final_slot = -1;
    for (int i = 0; i < NODE_SLOTS; i++) begin
      if (slot_listed(i)) begin
        final_slot = i;
      end
    end
    for (int i = 0; i < NODE_SLOTS; i++) begin
      if (slot_listed(i)) begin
        rep.kind = KIND_LIST;
        rep.id = ID_W'(i);
        rep.beat = member_beat[i];
        rep.outcome = OC_SELF;
        rep.last = (i == final_slot);
        expected_reports.insert(expected_reports.size(), rep);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    member_report_t want;
    if (!rst_ni) begin
      self_cfg = SELF_ID_RST;
      timeout_cfg = FAIL_TIMEOUT_RST;
      hold_cfg = TOMB_HOLD_RST;
      member_present = '0;
      tomb_valid = '0;
      for (int i = 0; i < NODE_SLOTS; i++) begin
        member_beat[i] = '0;
        member_seen_ms[i] = '0;
        tomb_stamp_ms[i] = '0;
      end
      expected_reports.delete();
      mismatch_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_SELF_ID: self_cfg = cfg_data_i[ID_W-1:0];
          REG_FAIL_TIMEOUT: timeout_cfg = cfg_data_i;
          REG_TOMB_HOLD: hold_cfg = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (mode_i == MODE_MERGE) begin
          fold_heartbeat_record(member_id_i, beat_i, now_ms_i);
        end else begin
          if (mode_i == MODE_ROUND) begin
            age_out_members(now_ms_i);
          end
          enumerate_members();
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_reports.size() == 0) begin
          report_mismatch("result with no request behind it, id", out_id_i, 0);
        end else begin
          want = expected_reports.pop_front();
          if (kind_i !== want.kind) report_mismatch("kind", kind_i, want.kind);
          if (out_id_i !== want.id) report_mismatch("out_id", out_id_i, want.id);
          if (out_beat_i !== want.beat) report_mismatch("out_beat", out_beat_i, want.beat);
          if (outcome_i !== want.outcome) report_mismatch("outcome", outcome_i, want.outcome);
          if (last_i !== want.last) report_mismatch("last", last_i, want.last);
        end
      end
    end
    reports_pending_o = expected_reports.size();
  end

endmodule

[dv/tb_gossip_membership_table.sv]
module tb_gossip_membership_table;
  timeunit 1ns;
  timeprecision 1ps;
  import gmt_pkg::*;

  localparam logic [MODE_W-1:0] MODE_LIST  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 80;
  localparam int SETTLE_CYCLES = 4 * NODE_SLOTS + 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 2_000_000;

  typedef struct packed {
    logic [ID_W-1:0]  self_id;
    logic [CFG_W-1:0] timeout;
    logic [CFG_W-1:0] hold;
  } setting_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic [MODE_W-1:0]    mode = '0;
  logic [ID_W-1:0]      member_id = '0;
  logic [BEAT_W-1:0]    beat = '0;
  logic [TIME_W-1:0]    now_ms = '0;
  logic                 out_ready = 1'b0;

  logic                 cfg_ready;
  logic                 in_ready;
  logic                 out_valid;
  logic                 kind;
  logic [ID_W-1:0]      out_id;
  logic [BEAT_W-1:0]    out_beat;
  logic [OUTC_W-1:0]    outcome;
  logic                 last;

  int                   reports_pending;
  int                   mismatch_count;
  int                   cycle_count = 0;

  logic                 calm = 1'b1;
  logic                 hold_req = 1'b0;
  logic [TIME_W-1:0]    clock_ms = '0;
  int unsigned          step_ms = 1000;
  logic [BEAT_W-1:0]    beat_track [NODE_SLOTS];

  gossip_membership_table dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .mode_i      (mode),
    .member_id_i (member_id),
    .beat_i      (beat),
    .now_ms_i    (now_ms),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .kind_o      (kind),
    .out_id_o    (out_id),
    .out_beat_o  (out_beat),
    .outcome_o   (outcome),
    .last_o      (last)
  );

  gossip_membership_table_checker u_check (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .mode_i            (mode),
    .member_id_i       (member_id),
    .beat_i            (beat),
    .now_ms_i          (now_ms),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .kind_i            (kind),
    .out_id_i          (out_id),
    .out_beat_i        (out_beat),
    .outcome_i         (outcome),
    .last_i            (last),
    .reports_pending_o (reports_pending),
    .mismatch_count_o  (mismatch_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("No progress within %0d cycles.", CYCLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic setting_t phase_setting(input int p);
    case (p)
      0: return {8'd0, 16'd5000, 16'd2000};
      1: return {8'd5, 16'd0, 16'd0};
      2: return {8'd15, 16'd65535, 16'd65535};
      3: return {8'd255, 16'd3000, 16'd1000};
      4: return {8'd16, 16'd1000, 16'd65535};
      default: return {8'd9, 16'd20000, 16'd500};
    endcase
  endfunction

  // The sink drops ready in random bursts, and once holds it low for a long stretch.
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        stall_left = gap_len();
      end
    end
  end

  task automatic pause_sender(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic send_request(input logic [MODE_W-1:0] m, input logic [ID_W-1:0] id,
                              input logic [BEAT_W-1:0] b, input logic [TIME_W-1:0] t);
    @(negedge clk);
    in_valid <= 1'b1;
    mode <= m;
    member_id <= id;
    beat <= b;
    now_ms <= t;
    do @(posedge clk); while (!in_ready);
    pause_sender(gap_len());
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (reports_pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // A list request with nothing listed leaves no result behind, so the table may still
  // be sweeping when the queue runs empty.
  task automatic apply_settings(input setting_t s);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(REG_SELF_ID, CFG_W'(s.self_id));
    write_reg(REG_FAIL_TIMEOUT, s.timeout);
    write_reg(REG_TOMB_HOLD, s.hold);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_directed();
    send_request(MODE_LIST, 8'd0, 32'd0, 32'd0);
    apply_settings({8'd200, 16'd5000, 16'd2000});
    send_request(MODE_SPARE, 8'hFF, FAREWELL_BEAT, 32'hFFFF_FFFF);
    send_request(MODE_ROUND, 8'd0, 32'd0, 32'd0);
    send_request(MODE_MERGE, 8'd200, 32'd7, 32'd10);
    send_request(MODE_MERGE, 8'd255, 32'd0, 32'd10);
    send_request(MODE_MERGE, 8'd16, 32'd0, 32'd10);
    send_request(MODE_MERGE, 8'd5, 32'hFFFF_FFFE, 32'd20);
    apply_settings({8'd5, 16'd5000, 16'd2000});
    send_request(MODE_ROUND, 8'd0, 32'd0, 32'd30);
    send_request(MODE_ROUND, 8'd0, 32'd0, 32'd40);
    send_request(MODE_MERGE, 8'd5, 32'd1, 32'd50);
    send_request(MODE_MERGE, 8'd3, 32'd0, 32'd100);
    send_request(MODE_MERGE, 8'd3, 32'd5, 32'd100);
    send_request(MODE_MERGE, 8'd3, 32'd5, 32'd100);
    send_request(MODE_MERGE, 8'd15, 32'hFFFF_FFFE, 32'd200);
    send_request(MODE_MERGE, 8'd3, FAREWELL_BEAT, 32'd300);
    send_request(MODE_MERGE, 8'd7, FAREWELL_BEAT, 32'd300);
    send_request(MODE_MERGE, 8'd3, 32'd9, 32'd2299);
    send_request(MODE_MERGE, 8'd3, 32'd9, 32'd2300);
    send_request(MODE_ROUND, 8'd0, 32'd0, 32'd2300);
    send_request(MODE_MERGE, 8'd9, 32'd1, 32'hFFFF_FF00);
    send_request(MODE_ROUND, 8'd0, 32'd0, 32'h0000_0100);
    send_request(MODE_MERGE, 8'd15, 32'd1, 32'h0000_0101);
    send_request(MODE_ROUND, 8'd0, 32'd0, 32'h0000_0200 + 32'd5000);
    send_request(MODE_ROUND, 8'd0, 32'd0, 32'h0000_0200 + 32'd5001);
  endtask

  task automatic random_request();
    int unsigned pick;
    logic [SLOT_W-1:0] slot;
    logic [BEAT_W-1:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 3) clock_ms = $urandom;
    else if (pick < 6) clock_ms = clock_ms - $urandom_range(1, 100);
    else clock_ms = clock_ms + $urandom_range(0, step_ms);
    slot = SLOT_W'($urandom_range(0, NODE_SLOTS - 1));
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      if ($urandom_range(0, 7) == 0) b = beat_track[slot] - $urandom_range(0, 2);
      else b = beat_track[slot] + $urandom_range(1, 500);
      if (b == FAREWELL_BEAT) b = '0;
      if (b > beat_track[slot]) beat_track[slot] = b;
      send_request(MODE_MERGE, ID_W'(slot), b, clock_ms);
    end else if (pick < 65) begin
      b = ($urandom_range(0, 3) == 0) ? FAREWELL_BEAT : BEAT_W'($urandom);
      send_request(MODE_MERGE, ID_W'($urandom_range(0, 255)), b, clock_ms);
    end else if (pick < 75) begin
      send_request(MODE_MERGE, ID_W'(slot), FAREWELL_BEAT, clock_ms);
    end else if (pick < 90) begin
      send_request(MODE_ROUND, ID_W'($urandom), BEAT_W'($urandom), clock_ms);
    end else begin
      send_request(($urandom_range(0, 3) == 0) ? MODE_SPARE : MODE_LIST,
                   ID_W'($urandom), BEAT_W'($urandom), clock_ms);
    end
  endtask

  initial begin : stimulus
    setting_t cur;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    run_directed();
    for (int p = 0; p < PHASES; p++) begin
      cur = phase_setting(p);
      apply_settings(cur);
      step_ms = cur.timeout / 4 + 50;
      for (int i = 0; i < NODE_SLOTS; i++) begin
        beat_track[i] = $urandom;
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        calm = (p == 3 && k < PHASE_ITEMS / 2);
        if (p == 1 && k == 10) hold_req = 1'b1;
        if (k == PHASE_ITEMS / 2) drain_results();
        random_request();
      end
    end
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && reports_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/gmt_pkg.sv
rtl/gmt_ram.sv
rtl/gmt_dp.sv
rtl/gmt_ctrl.sv
rtl/gossip_membership_table.sv
dv/gossip_membership_table_checker.sv
dv/tb_gossip_membership_table.sv
